[hdl/utf8s_pkg.sv]
// Shared types and constants for the UTF-8 sanitizer.
package utf8s_pkg;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Lead byte limits and second-byte range limits
  localparam logic [7:0] ASCII_END    = 8'h80;
  localparam logic [7:0] LEAD2_LO     = 8'hC2;
  localparam logic [7:0] LEAD2_HI     = 8'hDF;
  localparam logic [7:0] LEAD3_LO     = 8'hE0;
  localparam logic [7:0] LEAD3_HI     = 8'hEF;
  localparam logic [7:0] LEAD4_LO     = 8'hF0;
  localparam logic [7:0] LEAD4_HI     = 8'hF4;
  localparam logic [7:0] LEAD_E0      = 8'hE0;
  localparam logic [7:0] LEAD_ED      = 8'hED;
  localparam logic [7:0] LEAD_F0      = 8'hF0;
  localparam logic [7:0] LEAD_F4      = 8'hF4;
  localparam logic [7:0] CONT_A0      = 8'hA0;
  localparam logic [7:0] CONT_90      = 8'h90;
  localparam logic [1:0] CONT_TAG     = 2'b10;

  localparam int HELD_DEPTH = 3;
  localparam int PASS_MAX   = 4;

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = CMD_PTR_W + 1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  // One command: rep_cnt replacements, then pass_cnt raw bytes
  typedef struct packed {
    logic [2:0]            rep_cnt;
    logic [2:0]            pass_cnt;
    logic [PASS_MAX-1:0][7:0] pass_bytes;
    logic                  stream_end;
  } cmd_t;

endpackage

[hdl/utf8s_front.sv]
// Front end: decodes each input byte against the pending sequence and issues commands.
module utf8s_front
  import utf8s_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd
);

  logic [HELD_DEPTH-1:0][7:0] held_r, held_nxt;
  logic [1:0]                 hc_r, hc_nxt;
  logic [2:0]                 sl_r, sl_nxt;

  logic [7:0] b;
  logic       cont_ok;
  logic       do_start;
  logic [2:0] rep;
  logic [2:0] pass;

  assign b = in_data.in_byte;

  always_comb begin
    cont_ok = (b[7:6] == CONT_TAG);
    if (hc_r == 2'd1) begin
      if (held_r[0] == LEAD_E0 && b < CONT_A0) cont_ok = 1'b0;
      if (held_r[0] == LEAD_ED && b >= CONT_A0) cont_ok = 1'b0;
      if (held_r[0] == LEAD_F0 && b < CONT_90) cont_ok = 1'b0;
      if (held_r[0] == LEAD_F4 && b >= CONT_90) cont_ok = 1'b0;
    end
  end

  always_comb begin
    held_nxt = held_r;
    hc_nxt   = hc_r;
    sl_nxt   = sl_r;
    rep      = 3'd0;
    pass     = 3'd0;
    do_start = 1'b0;
    for (int k = 0; k < PASS_MAX; k++) begin
      cmd.pass_bytes[k] = (k < HELD_DEPTH && k < int'(hc_r)) ? held_r[k] : b;
    end

    if (hc_r == 2'd0) begin
      do_start = 1'b1;
    end else if (cont_ok) begin
      if ({1'b0, hc_r} + 3'd1 >= sl_r) begin
        pass   = {1'b0, hc_r} + 3'd1;
        hc_nxt = 2'd0;
        sl_nxt = 3'd0;
      end else begin
        for (int k = 0; k < HELD_DEPTH; k++) begin
          if (k == int'(hc_r)) held_nxt[k] = b;
        end
        hc_nxt = hc_r + 2'd1;
      end
    end else begin
      // drop the held bytes as replacements and rescan this byte
      rep      = {1'b0, hc_r};
      hc_nxt   = 2'd0;
      sl_nxt   = 3'd0;
      do_start = 1'b1;
    end

    if (do_start) begin
      if (b < ASCII_END) begin
        pass = 3'd1;
        for (int k = 0; k < PASS_MAX; k++) cmd.pass_bytes[k] = b;
      end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
        held_nxt[0] = b;
        hc_nxt      = 2'd1;
        sl_nxt      = 3'd2;
      end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
        held_nxt[0] = b;
        hc_nxt      = 2'd1;
        sl_nxt      = 3'd3;
      end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
        held_nxt[0] = b;
        hc_nxt      = 2'd1;
        sl_nxt      = 3'd4;
      end else begin
        rep = rep + 3'd1;
      end
    end

    if (in_data.stream_end) begin
      // flush whatever is still pending
      rep    = rep + {1'b0, hc_nxt};
      hc_nxt = 2'd0;
      sl_nxt = 3'd0;
    end

    cmd.rep_cnt    = rep;
    cmd.pass_cnt   = pass;
    cmd.stream_end = in_data.stream_end;
    cmd_valid      = accept && (rep != 3'd0 || pass != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= 2'd0;
      sl_r <= 3'd0;
    end else if (accept) begin
      hc_r <= hc_nxt;
      sl_r <= sl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
  end

endmodule

[hdl/utf8s_cmd_fifo.sv]
// Short command queue between the front end and the output sequencer.
module utf8s_cmd_fifo
  import utf8s_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic fifo_empty,
  output logic fifo_full
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r, count_nxt;

  assign rd_data    = mem_r[rd_ptr_r];
  assign fifo_empty = (count_r == '0);
  assign fifo_full  = (count_r == CMD_CNT_W'(CMD_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) count_nxt = count_r + 1'b1;
    if (rd_en && !wr_en) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[hdl/utf8s_back.sv]
// Back end: expands each command into output bytes, one per cycle while not stalled, into the output register.
module utf8s_back
  import utf8s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  logic      head_empty,
  output logic      head_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  logic       out_valid_r;
  out_item_t  out_r, out_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [1:0] phase_r, phase_nxt;

  logic [3:0] rep3;
  logic [3:0] total;
  logic [3:0] pidx;
  logic       in_rep;
  logic       last;
  logic       load;

  assign rep3   = {head.rep_cnt, 1'b0} + {1'b0, head.rep_cnt};
  assign total  = rep3 + {1'b0, head.pass_cnt};
  assign pidx   = idx_r - rep3;
  assign in_rep = (idx_r < rep3);
  assign last   = (idx_r == total - 4'd1);
  assign load   = !head_empty && (!out_valid_r || pop);
  assign head_pop = load && last;

  always_comb begin
    out_nxt.is_replacement = in_rep;
    out_nxt.run_last       = last;
    out_nxt.stream_done    = last && head.stream_end;
    if (in_rep) begin
      case (phase_r)
        2'd0:    out_nxt.out_byte = REPL_B0;
        2'd1:    out_nxt.out_byte = REPL_B1;
        default: out_nxt.out_byte = REPL_B2;
      endcase
    end else begin
      out_nxt.out_byte = head.pass_bytes[pidx[1:0]];
    end

    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    if (load) begin
      if (last) begin
        idx_nxt   = 4'd0;
        phase_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 4'd1;
        if (in_rep) phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      phase_r     <= 2'd0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      if (load)     out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

[hdl/utf8_sanitizer_unit.sv]
// UTF-8 sanitizer top level: front decoder, command queue, output sequencer.
// Path: the first result byte of an accepted request reaches the out ports through the queue
//   write and then the output register load, which waits while the output is stalled.
// Throughput: one request per cycle while the queue has room and each yields one byte at most;
//   output is one byte per cycle while popped; a request yields up to 12 bytes, one at a time.
// Reset: synchronous, active low; clears the pending count, the queue and the output valid flag.
//   Held sequence bytes are not cleared and are only read below the pending count.
module utf8_sanitizer_unit
  import utf8s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic head_empty;
  logic head_pop;

  assign accept = push && !full;

  utf8s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  utf8s_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cmd_valid),
    .wr_data    (cmd),
    .rd_en      (head_pop),
    .rd_data    (head),
    .fifo_empty (head_empty),
    .fifo_full  (full)
  );

  utf8s_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data)
  );

endmodule

[hdl/utf8s_checker.sv]
// Port-level checks for the UTF-8 sanitizer, bound to the top level.
module utf8s_checker
  import utf8s_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input in_item_t  in_data,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  // come out of reset with nothing queued
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue not clear after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.stream_done) |-> out_data.run_last)
    else $error("stream_done without run_last");

  a_repl_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.is_replacement) |->
      (out_data.out_byte == REPL_B0 || out_data.out_byte == REPL_B1 ||
       out_data.out_byte == REPL_B2))
    else $error("bad byte inside replacement");

  // a replacement lead is followed at once by its second byte
  a_repl_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_data.is_replacement && out_data.out_byte == REPL_B0) |=>
      (!empty && out_data.is_replacement && out_data.out_byte == REPL_B1))
    else $error("replacement sequence broken");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind utf8_sanitizer_unit utf8s_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .in_data  (in_data),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

[sim/utf8_sanitizer_checker.sv]
// Checker for the UTF-8 sanitizer: predicts result bytes and compares them on pop.
`timescale 1ns / 100ps

module utf8_sanitizer_checker
  import utf8s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_data,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        bytes_owed
);

  localparam int SEQ_IDLE = 0;

  logic [7:0] held [HELD_DEPTH];
  logic [1:0] held_cnt;
  logic [2:0] seq_len;
  out_item_t  sanitized_q [$];
  out_item_t  want;
  int         mismatches = 0;

  initial begin
    mismatch_count = 0;
    bytes_owed = 0;
  end

  function automatic void queue_byte(logic [7:0] b, logic repl);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.is_replacement = repl;
    sanitized_q.push_back(r);
  endfunction

  function automatic void queue_replacement();
    queue_byte(REPL_B0, 1'b1);
    queue_byte(REPL_B1, 1'b1);
    queue_byte(REPL_B2, 1'b1);
  endfunction

  // Turn every held byte into one replacement character
  function automatic void replace_held();
    for (int k = 0; k < int'(held_cnt); k++)
      queue_replacement();
    held_cnt = '0;
    seq_len = 3'(SEQ_IDLE);
  endfunction

  function automatic void open_sequence(logic [7:0] b);
    if (b < ASCII_END) begin
      queue_byte(b, 1'b0);
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      held[0] = b;
      held_cnt = 2'd1;
      seq_len = 3'd2;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      held[0] = b;
      held_cnt = 2'd1;
      seq_len = 3'd3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      held[0] = b;
      held_cnt = 2'd1;
      seq_len = 3'd4;
    end else begin
      queue_replacement();
    end
  endfunction

  function automatic void sanitize_byte(logic [7:0] b, logic last);
    int        n0;
    logic      ok;
    out_item_t tail;
    n0 = sanitized_q.size();
    if (held_cnt == 0) begin
      open_sequence(b);
    end else begin
      ok = (b[7:6] == CONT_TAG);
      // Second-byte limits after the special leads
      if (ok && held_cnt == 2'd1) begin
        if (held[0] == LEAD_E0 && b < CONT_A0) ok = 1'b0;
        if (held[0] == LEAD_ED && b >= CONT_A0) ok = 1'b0;
        if (held[0] == LEAD_F0 && b < CONT_90) ok = 1'b0;
        if (held[0] == LEAD_F4 && b >= CONT_90) ok = 1'b0;
      end
      if (!ok) begin
        replace_held();
        open_sequence(b);
      end else if (int'(held_cnt) + 1 >= int'(seq_len)) begin
        for (int k = 0; k < int'(held_cnt); k++)
          queue_byte(held[k], 1'b0);
        queue_byte(b, 1'b0);
        held_cnt = '0;
        seq_len = 3'(SEQ_IDLE);
      end else begin
        held[held_cnt] = b;
        held_cnt = held_cnt + 2'd1;
      end
    end
    if (last)
      replace_held();
    // Mark the final byte of this request
    if (sanitized_q.size() > n0) begin
      tail = sanitized_q.pop_back();
      tail.run_last = 1'b1;
      tail.stream_done = last;
      sanitized_q.push_back(tail);
    end
  endfunction

  task automatic check_field(string name, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_cnt = '0;
      seq_len = 3'(SEQ_IDLE);
      sanitized_q.delete();
    end else begin
      if (pop && !empty) begin
        if (sanitized_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %02h", $time,
                   out_data.out_byte);
          mismatches++;
        end else begin
          want = sanitized_q.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("is_replacement", want.is_replacement, out_data.is_replacement);
          check_field("run_last", want.run_last, out_data.run_last);
          check_field("stream_done", want.stream_done, out_data.stream_done);
        end
      end
      if (push && !full)
        sanitize_byte(in_data.in_byte, in_data.stream_end);
    end
    mismatch_count <= mismatches;
    bytes_owed <= sanitized_q.size();
  end

endmodule

[sim/utf8_sanitizer_unit_tb.sv]
// Testbench top for the UTF-8 sanitizer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module utf8_sanitizer_unit_tb
  import utf8s_pkg::*;
;

  localparam int         RANDOM_ITEMS   = 250;
  localparam int         CYCLE_LIMIT    = 200000;
  localparam int         RX_HOLD_CYCLES = 160;
  localparam int         HOLD_AT_ITEM   = 80;
  localparam int         PAUSE_AT_ITEM  = 160;
  localparam int         DRAIN_CYCLES   = 16;
  localparam logic [7:0] CONT_LO        = 8'h80;
  localparam logic [7:0] CONT_HI        = 8'hBF;
  localparam logic [7:0] ASCII_HI       = 8'h7F;

  // Extremes, every sequence length, special second bytes, bad leads, end flush
  localparam int         N_DIRECTED = 27;
  localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
    8'h00, 8'h7F,
    8'hDF, 8'hBF,
    8'hE0, 8'hA0, 8'h80,
    8'hED, 8'h9F, 8'hBF,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hF0, 8'h90, 8'h80, 8'hC1,
    8'hE0, 8'h9F,
    8'hED, 8'hA0,
    8'hF4, 8'h90,
    8'hF5, 8'hFF,
    8'hC2
  };

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  int         mismatch_count;
  int         bytes_owed;
  int         cycle_count = 0;
  int         hold_requests = 0;
  logic       rx_drain = 1'b0;
  int         burst_left = 0;
  int         gapless = 0;
  logic [7:0] text_q [$];

  utf8_sanitizer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  utf8_sanitizer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .empty          (empty),
    .pop            (pop),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .bytes_owed     (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Append one well-formed sequence of at least min_len bytes
  function automatic void add_well_formed(int min_len);
    int         len;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    len = $urandom_range(min_len, 4);
    if (len == 1) begin
      text_q.push_back(8'($urandom_range(0, ASCII_HI)));
    end else begin
      if (len == 2)
        lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
      else if (len == 3)
        lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? LEAD_E0 : LEAD_ED)
                                           : 8'($urandom_range(LEAD3_LO, LEAD3_HI));
      else
        lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? LEAD_F0 : LEAD_F4)
                                           : 8'($urandom_range(LEAD4_LO, LEAD4_HI));
      lo = CONT_LO;
      hi = CONT_HI;
      if (lead == LEAD_E0) lo = CONT_A0;
      if (lead == LEAD_ED) hi = CONT_A0 - 8'd1;
      if (lead == LEAD_F0) lo = CONT_90;
      if (lead == LEAD_F4) hi = CONT_90 - 8'd1;
      text_q.push_back(lead);
      text_q.push_back(8'($urandom_range(lo, hi)));
      repeat (len - 2) text_q.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
    end
  endfunction

  // Offer one request, hold it until accepted, then maybe drop push for a gap
  task automatic feed(input logic [7:0] b, input logic last);
    push <= 1'b1;
    in_data <= '{in_byte: b, stream_end: last};
    do @(posedge clk); while (full);
    if (gapless > 0) begin
      gapless--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Receiver: stall pattern that changes mode, plus long hold-offs on request
  initial begin
    int mode_left, stall_pct, hold_left, holds_served;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    holds_served = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= rx_drain || ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int random_sent;
    int pick;
    int n0;
    random_sent = 0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      feed(DIRECTED_BYTES[i], i == N_DIRECTED - 1);

    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_well_formed(1);
      end else if (pick < 85) begin
        // Break a multi-byte sequence: truncate it or corrupt a trailing byte
        n0 = text_q.size();
        add_well_formed(2);
        if ($urandom_range(0, 1))
          void'(text_q.pop_back());
        else
          text_q[$urandom_range(n0 + 1, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      while (text_q.size() > 0) begin
        feed(text_q.pop_front(), $urandom_range(0, 24) == 0);
        random_sent++;
        if (random_sent == HOLD_AT_ITEM) begin
          // Stall the receiver and keep offering so the block backs up
          hold_requests <= hold_requests + 1;
          gapless = 24;
        end
        if (random_sent == PAUSE_AT_ITEM) begin
          push <= 1'b0;
          @(posedge clk);
          while (bytes_owed != 0) @(posedge clk);
        end
      end
    end

    push <= 1'b0;
    rx_drain <= 1'b1;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && bytes_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
